// ===== sv/abl_pkg.sv =====
package abl_pkg;

   // fixed field widths
   localparam int BAND_W  = 3;
   localparam int VALUE_W = 12;
   localparam int LEVEL_W = 8;
   localparam int RMIN_W  = 12;
   localparam int LEDS_W  = 8;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   localparam logic [RMIN_W-1:0]  RMIN_RESET  = 12'd100;
   localparam logic [LEDS_W-1:0]  LEDS_RESET  = 8'd8;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 8'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;

   // register select, taken from paddr[2]
   localparam logic REG_RANGE_MIN = 1'b0;
   localparam logic REG_MAX_LEDS  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_AVG,
      ST_BOUND,
      ST_SPAN,
      ST_MUL,
      ST_TGT,
      ST_OUT
   } abl_state_type;

endpackage

// ===== sv/abl_ram.sv =====
module abl_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/abl_div.sv =====
module abl_div #(
   parameter int W  = 21,
   parameter int DW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [W-1:0]  dividend,
   input  logic [DW-1:0] divisor,
   output logic [W-1:0]  quotient,
   output logic          done
);

   localparam int CW = $clog2(W + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [DW:0] shifted;
   logic [DW:0] diff;
   logic        ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== sv/adaptive_band_level_tracker_top.sv =====
// Each accepted item scans the filled frames of its band (closed frames plus the open one,
// at most HISTORY_DEPTH), then makes two passes of the shared divider before rsp_valid.
// A new item is taken only once the last one is through; a held result stalls the next
// item's last step.
// Out-of-range bands are taken and dropped. History memory is not cleared.
// Reset (sync, active high): slot and frame count 0, levels 1, min span 100, max_leds 8.
module adaptive_band_level_tracker_top #(
   parameter int BANDS         = 7,
   parameter int HISTORY_DEPTH = 32,
   parameter int SAMPLE_BITS   = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   // sample items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [abl_pkg::BAND_W-1:0]    req_sample_band,
   input  logic [abl_pkg::VALUE_W-1:0]   req_sample_value,
   // level items
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [abl_pkg::BAND_W-1:0]    rsp_level_band,
   output logic [abl_pkg::LEVEL_W-1:0]   rsp_level,
   // APB-style register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [abl_pkg::ADDR_W-1:0]    paddr,
   input  logic [abl_pkg::DATA_W-1:0]    pwdata,
   output logic [abl_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   import abl_pkg::*;

   localparam int SW       = SAMPLE_BITS;
   localparam int SLOT_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W    = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W    = SW + $clog2(HISTORY_DEPTH);
   localparam int SPAN_W   = (SW > RMIN_W) ? SW : RMIN_W;
   localparam int MUL_W    = LEDS_W + 1;
   localparam int DIV_W    = SW + MUL_W;
   localparam int BIDX_W   = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int RADDR_W  = SLOT_W + BAND_W;
   localparam int RAM_DEPTH = (2 ** SLOT_W) * (2 ** BAND_W);

   // ---------------------------------------------------------------- registers
   abl_state_type        state_ff, state_in;
   logic [BAND_W-1:0]    band_ff, band_in;
   logic [SW-1:0]        samp_ff, samp_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [SW-1:0]        lo_ff, lo_in;
   logic [SW-1:0]        hi_ff, hi_in;
   logic [SUM_W-1:0]     total_ff, total_in;
   logic [SW-1:0]        fl_ff, fl_in;
   logic [SW-1:0]        ce_ff, ce_in;
   logic [SPAN_W-1:0]    span_ff, span_in;
   logic [SW-1:0]        above_ff, above_in;
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;

   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]     frames_ff, frames_in;
   logic [LEVEL_W-1:0]   levels_ff [BANDS];
   logic [LEVEL_W-1:0]   levels_in [BANDS];

   logic [RMIN_W-1:0]    rmin_ff, rmin_in;
   logic [LEDS_W-1:0]    leds_ff, leds_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BAND_W-1:0]    rsp_band_ff, rsp_band_in;
   logic [LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;

   // ---------------------------------------------------------------- datapath wires
   logic                 ram_we;
   logic [RADDR_W-1:0]   ram_waddr;
   logic [RADDR_W-1:0]   ram_raddr;
   logic [SW-1:0]        ram_wdata;
   logic [SW-1:0]        ram_rdata;

   logic                 div_start;
   logic [DIV_W-1:0]     div_dividend;
   logic [SPAN_W-1:0]    div_divisor;
   logic [DIV_W-1:0]     div_quo;
   logic                 div_done;

   logic                 band_ok;
   logic                 band_last;
   logic [SW-1:0]        avg;
   logic [SW+1:0]        fl_sum;
   logic [SW+1:0]        ce_sum;
   logic [SPAN_W-1:0]    diff;
   logic [SPAN_W-1:0]    span_sel;
   logic [MUL_W-1:0]     scale;
   logic [LEVEL_W-1:0]   lvl_cur;
   logic                 cfg_write;

   // ---------------------------------------------------------------- history memory
   // one row per ring slot, one column per band code
   abl_ram #(
      .WIDTH (SW),
      .DEPTH (RAM_DEPTH)
   ) u_hist (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------------- shared divider
   // first pass: sum / count for the average; second pass: scaled / span
   abl_div #(
      .W  (DIV_W),
      .DW (SPAN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .done     (div_done)
   );

   // ---------------------------------------------------------------- register port
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;

   always_comb begin
      unique case (paddr[2])
         REG_RANGE_MIN: prdata = DATA_W'(rmin_ff);
         REG_MAX_LEDS:  prdata = DATA_W'(leds_ff);
         default:       prdata = '0;
      endcase
   end

   always_comb begin
      rmin_in = rmin_ff;
      leds_in = leds_ff;
      if (cfg_write) begin
         unique case (paddr[2])
            REG_RANGE_MIN: rmin_in = pwdata[RMIN_W-1:0];
            REG_MAX_LEDS:  leds_in = pwdata[LEDS_W-1:0];
            default:       ;
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer
   assign req_ready = (state_ff == ST_IDLE);
   assign band_ok   = 32'(req_sample_band) < BANDS;
   assign band_last = 32'(band_ff) == (BANDS - 1);

   assign ram_raddr = {idx_ff[SLOT_W-1:0], band_ff};
   assign ram_waddr = {slot_ff, req_sample_band};
   assign ram_wdata = SW'(req_sample_value);

   // floor and ceil: (3*x + avg) / 4
   assign avg    = div_quo[SW-1:0];
   assign fl_sum = {1'b0, lo_ff, 1'b0} + {2'b00, lo_ff} + {2'b00, avg};
   assign ce_sum = {1'b0, hi_ff, 1'b0} + {2'b00, hi_ff} + {2'b00, avg};

   // span never below range_min, and never zero
   assign diff     = SPAN_W'(ce_ff - fl_ff);
   assign span_sel = (diff < SPAN_W'(rmin_ff)) ? SPAN_W'(rmin_ff) : diff;

   assign scale   = {1'b0, leds_ff} + MUL_W'(1);
   assign lvl_cur = levels_ff[BIDX_W'(band_ff)];

   always_comb begin
      state_in     = state_ff;
      band_in      = band_ff;
      samp_in      = samp_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      total_in     = total_ff;
      fl_in        = fl_ff;
      ce_in        = ce_ff;
      span_in      = span_ff;
      above_in     = above_ff;
      lvl_in       = lvl_ff;
      slot_in      = slot_ff;
      frames_in    = frames_ff;
      levels_in    = levels_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_band_in  = rsp_band_ff;
      rsp_level_in = rsp_level_ff;
      ram_we       = 1'b0;
      div_start    = 1'b0;
      div_dividend = DIV_W'(total_ff);
      div_divisor  = SPAN_W'(count_ff);

      unique case (state_ff)
         ST_IDLE: begin
            // out-of-range band items are taken and dropped
            if (req_valid && band_ok) begin
               ram_we   = 1'b1;
               band_in  = req_sample_band;
               samp_in  = SW'(req_sample_value);
               count_in = (frames_ff == CNT_W'(HISTORY_DEPTH)) ? frames_ff
                                                               : frames_ff + CNT_W'(1);
               idx_in   = '0;
               lo_in    = '1;
               hi_in    = '0;
               total_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one read per filled frame; data lands in the next cycle
            if (idx_ff != count_ff) begin
               idx_in  = idx_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (ram_rdata < lo_ff) lo_in = ram_rdata;
               if (ram_rdata > hi_ff) hi_in = ram_rdata;
               total_in = total_ff + SUM_W'(ram_rdata);
            end
            if (idx_ff == count_ff && !pend_ff) begin
               div_start = 1'b1;
               state_in  = ST_AVG;
            end
         end
         ST_AVG: begin
            if (div_done) begin
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            fl_in    = fl_sum[SW+1:2];
            ce_in    = ce_sum[SW+1:2];
            state_in = ST_SPAN;
         end
         ST_SPAN: begin
            span_in  = (span_sel == '0) ? SPAN_W'(1) : span_sel;
            above_in = (samp_ff > fl_ff) ? samp_ff - fl_ff : '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // product goes straight into the divider's operand register
            div_start    = 1'b1;
            div_dividend = DIV_W'(above_ff) * DIV_W'(scale);
            div_divisor  = span_ff;
            state_in     = ST_TGT;
         end
         ST_TGT: begin
            if (div_done) begin
               lvl_in = lvl_cur;
               if (div_quo > DIV_W'(lvl_cur)) begin
                  if (lvl_cur != LEVEL_MAX) lvl_in = lvl_cur + LEVEL_W'(1);
               end else if (div_quo < DIV_W'(lvl_cur) && lvl_cur > LEVEL_MIN) begin
                  lvl_in = lvl_cur - LEVEL_W'(1);
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_band_in                = band_ff;
               rsp_level_in               = lvl_ff;
               levels_in[BIDX_W'(band_ff)] = lvl_ff;
               if (band_last) begin
                  slot_in = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                  : slot_ff + SLOT_W'(1);
                  if (frames_ff != CNT_W'(HISTORY_DEPTH)) frames_in = frames_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         slot_ff      <= '0;
         frames_ff    <= '0;
         rmin_ff      <= RMIN_RESET;
         leds_ff      <= LEDS_RESET;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < BANDS; b++) begin
            levels_ff[b] <= LEVEL_RESET;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         slot_ff      <= slot_in;
         frames_ff    <= frames_in;
         rmin_ff      <= rmin_in;
         leds_ff      <= leds_in;
         rsp_valid_ff <= rsp_valid_in;
         levels_ff    <= levels_in;
      end
   end

   // ---------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      band_ff      <= band_in;
      samp_ff      <= samp_in;
      count_ff     <= count_in;
      idx_ff       <= idx_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      total_ff     <= total_in;
      fl_ff        <= fl_in;
      ce_ff        <= ce_in;
      span_ff      <= span_in;
      above_ff     <= above_in;
      lvl_ff       <= lvl_in;
      rsp_band_ff  <= rsp_band_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_level_band = rsp_band_ff;
   assign rsp_level      = rsp_level_ff;

endmodule

// ===== tb/adaptive_band_level_tracker_top_test.sv =====
`timescale 1ns / 100ps

module adaptive_band_level_tracker_top_test;

   // block geometry, kept at the default build
   localparam int BANDS      = 7;
   localparam int HIST_DEPTH = 32;
   localparam int VALUE_BITS = 12;
   localparam int VALUE_MAX  = 4095;

   // settle a little past the worst accept-to-result latency
   localparam int SETTLE_CYCLES  = 100;
   // quiet cycles (no item, no level, no register access) before giving up
   localparam int WATCHDOG_LIMIT = 2000;
   // percent of cycles in which a side holds off
   localparam int IDLE_PCT = 23;
   localparam int PHASE_SAMPLES = 150;

   typedef logic [abl_pkg::BAND_W-1:0]  band_type;
   typedef logic [abl_pkg::VALUE_W-1:0] value_type;
   typedef logic [abl_pkg::LEVEL_W-1:0] level_type;
   typedef logic [abl_pkg::ADDR_W-1:0]  addr_type;
   typedef logic [abl_pkg::DATA_W-1:0]  data_type;

   typedef struct packed {
      band_type  band;
      level_type level;
   } level_item_type;

   localparam band_type LAST_BAND         = band_type'(BANDS - 1);
   localparam band_type OUT_OF_RANGE_BAND = band_type'(7);   // no such band, block drops it

   // register byte addresses: index 0 and 1, four bytes apart
   localparam addr_type ADDR_RANGE_MIN = {abl_pkg::REG_RANGE_MIN, 2'b00};
   localparam addr_type ADDR_MAX_LEDS  = {abl_pkg::REG_MAX_LEDS, 2'b00};

   // ------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic      clock            = 1'b0;
   logic      reset            = 1'b1;
   logic      req_valid        = 1'b0;
   logic      req_ready;
   band_type  req_sample_band  = '0;
   value_type req_sample_value = '0;
   logic      rsp_valid;
   logic      rsp_ready        = 1'b0;
   band_type  rsp_level_band;
   level_type rsp_level;
   logic      psel             = 1'b0;
   logic      penable          = 1'b0;
   logic      pwrite           = 1'b0;
   addr_type  paddr            = '0;
   data_type  pwdata           = '0;
   data_type  prdata;
   logic      pready;

   adaptive_band_level_tracker_top #(
      .BANDS         (BANDS),
      .HISTORY_DEPTH (HIST_DEPTH),
      .SAMPLE_BITS   (VALUE_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_band  (req_sample_band),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_level_band   (rsp_level_band),
      .rsp_level        (rsp_level),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Level tracker prediction: own copy of history ring, frame counters,
   // band levels and the two registers
   // ------------------------------------------------------------------
   value_type   history [HIST_DEPTH][BANDS];
   int unsigned ring_slot;
   int unsigned frames_seen;      // closed frames, saturates at HIST_DEPTH
   level_type   band_level [BANDS];
   int unsigned span_floor_cfg;   // smallest allowed span
   int unsigned leds_cfg;         // max_leds

   level_item_type expected_levels [$];
   int unsigned mismatches    = 0;
   int unsigned samples_sent  = 0;   // in-range items only
   bit          no_idle       = 1'b0;
   int          band_center [BANDS];

   // Write the sample into the open frame, scan the filled frames of its band,
   // derive floor/ceiling and the scaled target, then step the level by one.
   function automatic level_type step_band_level(input band_type band, input value_type value);
      int unsigned frames, lo, hi, total, avg, fl, ce, span, above, target, lvl;
      history[ring_slot][band] = value;
      frames = (frames_seen + 1 > HIST_DEPTH) ? HIST_DEPTH : frames_seen + 1;
      lo = VALUE_MAX;
      hi = 0;
      total = 0;
      for (int i = 0; i < frames; i++) begin
         if (history[i][band] < lo) lo = history[i][band];
         if (history[i][band] > hi) hi = history[i][band];
         total += history[i][band];
      end
      avg  = total / frames;
      fl   = (3 * lo + avg) / 4;
      ce   = (3 * hi + avg) / 4;
      span = ce - fl;
      if (span < span_floor_cfg) span = span_floor_cfg;
      // zero span only when the span floor is zero and ceiling equals floor
      if (span == 0) span = 1;
      above  = (value > fl) ? value - fl : 0;
      target = (above * (leds_cfg + 1)) / span;
      lvl    = band_level[band];
      if (target > lvl) begin
         if (lvl < abl_pkg::LEVEL_MAX) lvl++;
      end else if (target < lvl && lvl > abl_pkg::LEVEL_MIN) begin
         lvl--;
      end
      band_level[band] = level_type'(lvl);
      // last band closes the frame
      if (band == LAST_BAND) begin
         ring_slot = (ring_slot + 1) % HIST_DEPTH;
         if (frames_seen < HIST_DEPTH) frames_seen++;
      end
      return level_type'(lvl);
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t MISMATCH: %s", $realtime, what);
   endtask

   // ------------------------------------------------------------------
   // Level checker: every accepted level item against the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      level_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_levels.size() == 0) begin
            report_mismatch($sformatf("unexpected level item band %0d level %0d",
                                      rsp_level_band, rsp_level));
         end else begin
            want = expected_levels.pop_front();
            if (rsp_level_band !== want.band)
               report_mismatch($sformatf("level_band %0d, want %0d",
                                         rsp_level_band, want.band));
            if (rsp_level !== want.level)
               report_mismatch($sformatf("level %0d, want %0d (band %0d)",
                                         rsp_level, want.level, want.band));
         end
      end
   end

   // receiver stalls at random unless a no-idle stretch is running
   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // watchdog: any handshake or register access counts as progress
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("adaptive_band_level_tracker_top_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sample driver: random hold-off, then valid held until accepted.
   // Leaves valid high; the next call or hold_off_input changes it
   // before the next rising edge.
   // ------------------------------------------------------------------
   task automatic send_sample(input band_type band, input value_type value);
      int unsigned gap;
      gap = 0;
      if (!no_idle) begin
         while ($urandom_range(0, 99) < IDLE_PCT) gap++;
         // now and then a long gap so the item lands after the block went idle
         if ($urandom_range(0, 15) == 0) gap += $urandom_range(1, 90);
      end
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_band  <= band;
      req_sample_value <= value;
      do @(posedge clock); while (!req_ready);
      if (band < BANDS) begin
         expected_levels.push_back('{band: band, level: step_band_level(band, value)});
         samples_sent++;
      end
   endtask

   task automatic hold_off_input();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_levels.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   task automatic csr_write(input addr_type addr, input data_type data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_read(input addr_type addr, input data_type want);
      data_type got;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== want)
         report_mismatch($sformatf("register @%0d reads %0d, want %0d", addr, got, want));
   endtask

   // Registers change only with the block idle: nothing pending and the
   // tail of any dropped out-of-range item long gone.
   task automatic set_config(input int unsigned range_min, input int unsigned leds);
      hold_off_input();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(ADDR_RANGE_MIN, data_type'(range_min));
      csr_write(ADDR_MAX_LEDS, data_type'(leds));
      span_floor_cfg = range_min;
      leds_cfg       = leds;
      csr_read(ADDR_RANGE_MIN, data_type'(range_min));
      csr_read(ADDR_MAX_LEDS, data_type'(leds));
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // mix of rails, values clustered around a per-band center, and full range
   function automatic value_type pick_value(input band_type band);
      int v;
      case ($urandom_range(0, 7))
         0:       v = 0;
         1:       v = VALUE_MAX;
         2, 3, 4: v = band_center[band] + int'($urandom_range(0, 400)) - 200;
         default: v = $urandom_range(0, VALUE_MAX);
      endcase
      if (v < 0) v = 0;
      if (v > VALUE_MAX) v = VALUE_MAX;
      return value_type'(v);
   endfunction

   // Fixed values for bands 0..6 in order; optional out-of-range items in between.
   task automatic send_pattern(input value_type vals [BANDS], input bit with_noise);
      for (int b = 0; b < BANDS; b++) begin
         send_sample(band_type'(b), vals[b]);
         if (with_noise && (b == 2 || b == 5))
            send_sample(OUT_OF_RANGE_BAND,
                        (b == 2) ? value_type'(VALUE_MAX) : value_type'(0));
      end
   endtask

   // One frame. Every band 0..BANDS-2 gets at least one item before the
   // closing band, so no unwritten history is ever scanned. A scrambled frame
   // shuffles the order and mixes in repeats and out-of-range items.
   task automatic send_frame(input bit scrambled);
      band_type    order [BANDS-1];
      band_type    swap;
      int unsigned pick;
      for (int i = 0; i < BANDS - 1; i++) order[i] = band_type'(i);
      if (scrambled) begin
         for (int i = BANDS - 2; i > 0; i--) begin
            pick        = $urandom_range(0, i);
            swap        = order[i];
            order[i]    = order[pick];
            order[pick] = swap;
         end
      end
      for (int i = 0; i < BANDS - 1; i++) begin
         send_sample(order[i], pick_value(order[i]));
         if (scrambled && $urandom_range(0, 99) < 30) begin
            pick = $urandom_range(0, i);
            send_sample(order[pick], pick_value(order[pick]));
         end
         if (scrambled && $urandom_range(0, 99) < 25)
            send_sample(OUT_OF_RANGE_BAND, value_type'($urandom_range(0, VALUE_MAX)));
      end
      send_sample(LAST_BAND, pick_value(LAST_BAND));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // registers come out of reset at their documented values
   task automatic test_register_reset();
      csr_read(ADDR_RANGE_MIN, data_type'(abl_pkg::RMIN_RESET));
      csr_read(ADDR_MAX_LEDS, data_type'(abl_pkg::LEDS_RESET));
   endtask

   // Rails on every band, dropped out-of-range items, and the zero span:
   // with the span floor at zero the first frame holds flat history, so
   // ceiling equals floor and the divisor falls back to one.
   task automatic test_directed();
      value_type rails_a [BANDS] = '{0, 4095, 1, 4094, 2048, 4095, 0};
      value_type rails_b [BANDS] = '{4095, 0, 4094, 1, 0, 2048, 4095};
      value_type rails_c [BANDS] = '{4095, 0, 4095, 0, 4095, 0, 4095};
      set_config(0, 254);
      send_pattern(rails_a, 1'b1);
      set_config(1, 0);
      send_pattern(rails_b, 1'b0);
      set_config(4095, 254);
      send_pattern(rails_c, 1'b1);
   endtask

   // Band 0 holds a zero from the first frame, so a run of full-scale items
   // drives its target past 255: the level climbs and sticks at the top,
   // then a run of zeros walks it back down.
   task automatic test_level_saturation();
      set_config(1, 254);
      repeat (260) send_sample(band_type'(0), value_type'(VALUE_MAX));
      for (int b = 1; b < BANDS; b++) send_sample(band_type'(b), pick_value(band_type'(b)));
      repeat (20) send_sample(band_type'(0), value_type'(0));
      for (int b = 1; b < BANDS; b++) send_sample(band_type'(b), pick_value(band_type'(b)));
   endtask

   // Random frames under several register settings, extremes included.
   // One phase runs with no idling on either side.
   task automatic test_random_frames();
      int unsigned range_mins [6] = '{100, 4095, 1, 0, 0, 1};
      int unsigned leds_list  [6] = '{8, 254, 1, 0, 0, 254};
      int unsigned start;
      range_mins[4] = $urandom_range(0, VALUE_MAX);
      leds_list[4]  = $urandom_range(0, 255);
      for (int p = 0; p < 6; p++) begin
         set_config(range_mins[p], leds_list[p]);
         for (int b = 0; b < BANDS; b++) band_center[b] = $urandom_range(0, VALUE_MAX);
         no_idle = (p == 2);
         start   = samples_sent;
         while (samples_sent - start < PHASE_SAMPLES)
            send_frame($urandom_range(0, 99) < 30);
         no_idle = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      ring_slot      = 0;
      frames_seen    = 0;
      span_floor_cfg = abl_pkg::RMIN_RESET;
      leds_cfg       = abl_pkg::LEDS_RESET;
      for (int b = 0; b < BANDS; b++) begin
         band_level[b]  = abl_pkg::LEVEL_RESET;
         band_center[b] = VALUE_MAX / 2;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_reset();
      test_directed();
      test_level_saturation();
      test_random_frames();

      // drain, then give a stray level item time to show up
      hold_off_input();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("adaptive_band_level_tracker_top_test: PASS");
      end else begin
         $display("adaptive_band_level_tracker_top_test: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/abl_pkg.sv
sv/abl_ram.sv
sv/abl_div.sv
sv/adaptive_band_level_tracker_top.sv
tb/adaptive_band_level_tracker_top_test.sv
